[src/assert_macros.svh]
// assertion macros used by the port level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("assertion failed");

// property that must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, prop) \
	`ASSERT_CLK(label, clk, rst_n, !(prop))

`endif

[src/fbfa_pkg.sv]
// shared types, codes and defaults of the block allocator
package fbfa_pkg;

	// default sizes
	localparam int NUM_BLOCKS_DEF = 32;
	localparam int SIZE_WIDTH_DEF = 16;

	// fixed field widths
	localparam int LOAD_IDX_W = 5;
	localparam int CHOSEN_W   = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 2'd1;

	// register reset values
	localparam logic [CFG_DATA_W-1:0] BLOCK_COUNT_RST = 6'd32;

	// request modes
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_ALLOC = 1'b1;

	// fit policies
	localparam logic POLICY_FIRST = 1'b0;
	localparam logic POLICY_BEST  = 1'b1;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE
	} state_t;

	// compare unit verdict
	typedef struct packed {
		logic hit;
		logic better;
	} cmp_res_t;

endpackage

[src/fbfa_ram.sv]
// generic single write, single read ram with registered read data
module fbfa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

[src/fbfa_cmp.sv]
// shared compare unit: entry space against request size and current best
module fbfa_cmp #(
	parameter int SIZE_WIDTH = fbfa_pkg::SIZE_WIDTH_DEF
) (
	input  logic [SIZE_WIDTH-1:0] space,
	input  logic [SIZE_WIDTH-1:0] req_size,
	input  logic [SIZE_WIDTH-1:0] best_space,
	input  logic                  found,
	output fbfa_pkg::cmp_res_t    res
);
	import fbfa_pkg::*;

	// entry fits, and beats the best so far (strictly smaller keeps lowest index)
	always_comb begin
		res.hit    = (space >= req_size);
		res.better = res.hit && (!found || (space < best_space));
	end

endmodule

[src/first_best_fit_block_allocator_unit.sv]
// first fit / best fit block allocator top level
//
//  channel   | handshake          | payload
//  ----------+--------------------+----------------------------------
//  request   | start / busy       | mode, load_index, size
//  result    | done (one cycle)   | granted, chosen_block, space_left
//  config    | wr_en              | wr_index, wr_data
//
// a load writes its table entry when accepted and gives no result; busy stays low
// an allocation keeps busy high through the scan (limit = min(block_count,
// NUM_BLOCKS)), one ram read and one compare per cycle, then a write-back;
// with limit zero only the write-back state is busy; done follows in the next cycle
// first fit ends the scan at the first hit and goes to the write-back
// reset clears control state and the configuration registers; the ram holds no reset value
// results cannot be stalled; a new request is taken while done is shown
module first_best_fit_block_allocator_unit #(
	parameter int NUM_BLOCKS = fbfa_pkg::NUM_BLOCKS_DEF,
	parameter int SIZE_WIDTH = fbfa_pkg::SIZE_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// request channel
	input  logic                            start,
	output logic                            busy,
	input  logic                            mode,
	input  logic [fbfa_pkg::LOAD_IDX_W-1:0] load_index,
	input  logic [SIZE_WIDTH-1:0]           size,
	// result channel
	output logic                            done,
	output logic                            granted,
	output logic [fbfa_pkg::CHOSEN_W-1:0]   chosen_block,
	output logic [SIZE_WIDTH-1:0]           space_left,
	// configuration
	input  logic                            wr_en,
	input  logic [fbfa_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [fbfa_pkg::CFG_DATA_W-1:0] wr_data
);
	import fbfa_pkg::*;

	localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

	state_t state_q, state_d;

	logic                  fit_policy_q;
	logic [CFG_DATA_W-1:0] block_count_q;

	logic [SIZE_WIDTH-1:0] size_q;
	logic [CNT_W-1:0]      limit_q;
	logic [CNT_W-1:0]      scan_q;
	logic                  pend_q;
	logic [IDX_W-1:0]      pend_idx_q;
	logic                  found_q;
	logic [IDX_W-1:0]      best_idx_q;
	logic [SIZE_WIDTH-1:0] best_space_q;

	logic                  done_q;
	logic                  granted_q;
	logic [CHOSEN_W-1:0]   chosen_q;
	logic [SIZE_WIDTH-1:0] space_q;

	logic                  accept;
	logic                  accept_alloc;
	logic [CNT_W-1:0]      limit_new;
	logic                  issue;
	logic                  last_cmp;
	logic                  stop;

	logic                  ram_we;
	logic [IDX_W-1:0]      ram_waddr;
	logic [SIZE_WIDTH-1:0] ram_wdata;
	logic [IDX_W-1:0]      ram_raddr;
	logic [SIZE_WIDTH-1:0] ram_rdata;
	logic [SIZE_WIDTH-1:0] left_space;

	cmp_res_t              cmp;

	// free space table
	fbfa_ram #(
		.WIDTH (SIZE_WIDTH),
		.DEPTH (NUM_BLOCKS),
		.ADDR_W(IDX_W)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// one compare per cycle on the entry just read
	fbfa_cmp #(
		.SIZE_WIDTH(SIZE_WIDTH)
	) u_cmp (
		.space     (ram_rdata),
		.req_size  (size_q),
		.best_space(best_space_q),
		.found     (found_q),
		.res       (cmp)
	);

	// request acceptance and search limit
	always_comb begin
		accept       = start && (state_q == ST_IDLE);
		accept_alloc = accept && (mode == MODE_ALLOC);
		if (32'(block_count_q) > NUM_BLOCKS) begin
			limit_new = CNT_W'(NUM_BLOCKS);
		end else begin
			limit_new = CNT_W'(block_count_q);
		end
	end

	// scan progress
	always_comb begin
		issue     = (state_q == ST_SCAN) && (scan_q < limit_q);
		last_cmp  = (CNT_W'(pend_idx_q) == CNT_W'(limit_q - CNT_W'(1)));
		stop      = pend_q && ((cmp.hit && (fit_policy_q == POLICY_FIRST)) || last_cmp);
		left_space = best_space_q - size_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept_alloc) begin
					state_d = (limit_new == '0) ? ST_WRITE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stop) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer outputs: ram port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = IDX_W'(load_index);
		ram_wdata = size;
		ram_raddr = IDX_W'(scan_q);
		case (state_q)
			ST_IDLE: begin
				ram_we = accept && (mode == MODE_LOAD) && (32'(load_index) < NUM_BLOCKS);
			end
			ST_WRITE: begin
				ram_we    = found_q;
				ram_waddr = best_idx_q;
				ram_wdata = left_space;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_policy_q  <= POLICY_FIRST;
			block_count_q <= BLOCK_COUNT_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_FIT_POLICY:  fit_policy_q  <= wr_data[0];
				REG_BLOCK_COUNT: block_count_q <= wr_data;
				default: ;
			endcase
		end
	end

	// scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q  <= '0;
			pend_q  <= 1'b0;
			found_q <= 1'b0;
		end else if (accept_alloc) begin
			scan_q  <= '0;
			pend_q  <= 1'b0;
			found_q <= 1'b0;
		end else if (state_q == ST_SCAN) begin
			pend_q <= issue;
			if (issue) begin
				scan_q <= scan_q + CNT_W'(1);
			end
			if (pend_q && cmp.better) begin
				found_q <= 1'b1;
			end
		end
	end

	// scan payload
	always_ff @(posedge clk) begin
		if (accept_alloc) begin
			size_q  <= size;
			limit_q <= limit_new;
		end
		if (issue) begin
			pend_idx_q <= IDX_W'(scan_q);
		end
		if ((state_q == ST_SCAN) && pend_q && cmp.better) begin
			best_idx_q   <= pend_idx_q;
			best_space_q <= ram_rdata;
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_WRITE);
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_WRITE) begin
			granted_q <= found_q;
			chosen_q  <= found_q ? CHOSEN_W'(best_idx_q) : '0;
			space_q   <= found_q ? left_space : '0;
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign done         = done_q;
	assign granted      = granted_q;
	assign chosen_block = chosen_q;
	assign space_left   = space_q;

endmodule

[src/fbfa_checker.sv]
// port level checker for the block allocator, bound to the top level
`include "assert_macros.svh"

module fbfa_checker #(
	parameter int SIZE_WIDTH = fbfa_pkg::SIZE_WIDTH_DEF
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            start,
	input logic                            busy,
	input logic                            mode,
	input logic                            done,
	input logic                            granted,
	input logic [fbfa_pkg::CHOSEN_W-1:0]   chosen_block,
	input logic [SIZE_WIDTH-1:0]           space_left
);
	import fbfa_pkg::*;

	// an allocation request keeps the block busy in the next cycle
	`ASSERT_CLK(a_alloc_busy, clk, arst_n, (start && !busy && mode == MODE_ALLOC) |=> busy)

	// a load request never produces a result
	`ASSERT_CLK(a_load_silent, clk, arst_n, (start && !busy && mode == MODE_LOAD) |=> !done)

	// a result is shown once the search is over
	`ASSERT_NEVER(a_done_idle, clk, arst_n, done && busy)

	// a result strobe lasts one cycle
	`ASSERT_CLK(a_done_pulse, clk, arst_n, done |=> !done)

	// a refused request reports zero index and space
	`ASSERT_CLK(a_refused_zero, clk, arst_n,
		(done && !granted) |-> (chosen_block == '0 && space_left == '0))

endmodule

bind first_best_fit_block_allocator_unit fbfa_checker #(.SIZE_WIDTH(SIZE_WIDTH)) u_fbfa_checker (.*);

[sim/fbfa_alloc_checker.sv]
`timescale 1ns / 100ps
// checker that follows the allocator channels, predicts every grant and compares it
module fbfa_alloc_checker #(
	parameter int NUM_BLOCKS = fbfa_pkg::NUM_BLOCKS_DEF,
	parameter int SIZE_WIDTH = fbfa_pkg::SIZE_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            busy,
	input  logic                            mode,
	input  logic [fbfa_pkg::LOAD_IDX_W-1:0] load_index,
	input  logic [SIZE_WIDTH-1:0]           size,
	input  logic                            done,
	input  logic                            granted,
	input  logic [fbfa_pkg::CHOSEN_W-1:0]   chosen_block,
	input  logic [SIZE_WIDTH-1:0]           space_left,
	input  logic                            wr_en,
	input  logic [fbfa_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [fbfa_pkg::CFG_DATA_W-1:0] wr_data,
	output int                              fail_count,
	output int                              outstanding
);
	import fbfa_pkg::*;

	typedef struct packed {
		logic                  granted;
		logic [CHOSEN_W-1:0]   blk;
		logic [SIZE_WIDTH-1:0] left;
	} grant_t;

	// own copy of the free space table and the registers
	logic [SIZE_WIDTH-1:0] free_space [NUM_BLOCKS];
	logic                  fit_policy;
	logic [CFG_DATA_W-1:0] blocks_in_use;
	grant_t                expected_grants [$];
	grant_t                oldest;

	initial fail_count = 0;

	// one line per mismatch, and count it
	task automatic report_mismatch(input string msg);
		fail_count++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	// search the table as the block does and take the size from the chosen entry
	function automatic grant_t predict_allocation(input logic [SIZE_WIDTH-1:0] need);
		grant_t res;
		int     scan_len;
		bit     found;
		int     pick;
		res = '0;
		found = 1'b0;
		pick = 0;
		scan_len = (blocks_in_use > NUM_BLOCKS) ? NUM_BLOCKS : int'(blocks_in_use);
		for (int j = 0; j < scan_len; j++) begin
			if (free_space[j] >= need) begin
				if (!found) begin
					found = 1'b1;
					pick = j;
					if (fit_policy == POLICY_FIRST) break;
				end else if (free_space[j] < free_space[pick]) begin
					pick = j;
				end
			end
		end
		if (found) begin
			free_space[pick] = free_space[pick] - need;
			res.granted = 1'b1;
			res.blk = CHOSEN_W'(pick);
			res.left = free_space[pick];
		end
		return res;
	endfunction

	// watch results, register writes and accepted requests on every edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NUM_BLOCKS; j++) free_space[j] = '0;
			fit_policy = POLICY_FIRST;
			blocks_in_use = BLOCK_COUNT_RST;
			expected_grants.delete();
			outstanding <= 0;
		end else begin
			// result side: compare with the oldest open request
			if (done) begin
				if (expected_grants.size() == 0) begin
					report_mismatch("result strobe with no request open");
				end else begin
					oldest = expected_grants.pop_front();
					if (granted !== oldest.granted)
						report_mismatch($sformatf("granted got %0b expected %0b",
							granted, oldest.granted));
					if (chosen_block !== oldest.blk)
						report_mismatch($sformatf("chosen_block got %0d expected %0d",
							chosen_block, oldest.blk));
					if (space_left !== oldest.left)
						report_mismatch($sformatf("space_left got %0d expected %0d",
							space_left, oldest.left));
				end
			end
			// register writes, unknown indexes do nothing
			if (wr_en) begin
				case (wr_index)
					REG_FIT_POLICY: begin
						fit_policy = wr_data[0];
					end
					REG_BLOCK_COUNT: begin
						blocks_in_use = wr_data;
					end
					default: begin
					end
				endcase
			end
			// accepted request: loads update the table, allocations queue a grant
			if (start && !busy) begin
				if (mode == MODE_ALLOC) begin
					expected_grants.push_back(predict_allocation(size));
				end else if (load_index < NUM_BLOCKS) begin
					free_space[load_index] = size;
				end
			end
			outstanding <= expected_grants.size();
		end
	end

endmodule

[sim/tb_first_best_fit_block_allocator_unit.sv]
`timescale 1ns / 100ps
// top of the allocator testbench: clock, reset, stimulus and verdict
module tb_first_best_fit_block_allocator_unit;
	import fbfa_pkg::*;

	localparam int NB          = NUM_BLOCKS_DEF;
	localparam int SW          = SIZE_WIDTH_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES      = 9;
	localparam int PHASE_ITEMS = 44;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic                  mode = MODE_LOAD;
	logic [LOAD_IDX_W-1:0] load_index = '0;
	logic [SW-1:0]         size = '0;
	logic                  done;
	logic                  granted;
	logic [CHOSEN_W-1:0]   chosen_block;
	logic [SW-1:0]         space_left;
	logic                  wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  wr_index = '0;
	logic [CFG_DATA_W-1:0] wr_data = '0;

	int fail_count;
	int outstanding;
	int cycles = 0;
	int loads_sent = 0;
	int allocs_sent = 0;
	int reg_writes = 0;
	bit gaps_on = 1'b0;
	logic [SW-1:0] last_load [NB];

	first_best_fit_block_allocator_unit #(
		.NUM_BLOCKS(NB),
		.SIZE_WIDTH(SW)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.load_index(load_index),
		.size(size),
		.done(done),
		.granted(granted),
		.chosen_block(chosen_block),
		.space_left(space_left),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	fbfa_alloc_checker #(
		.NUM_BLOCKS(NB),
		.SIZE_WIDTH(SW)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.load_index(load_index),
		.size(size),
		.done(done),
		.granted(granted),
		.chosen_block(chosen_block),
		.space_left(space_left),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// watchdog on the whole run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("** first_best_fit_block_allocator_unit: FAILED **");
			$finish;
		end
	end

	// mostly no gap, some short ones, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!gaps_on || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 60);
	endfunction

	// present one request and hold it until the block takes it
	task automatic send_request(input logic m, input logic [LOAD_IDX_W-1:0] idx,
			input logic [SW-1:0] sz);
		int gap;
		start <= 1'b1;
		mode <= m;
		load_index <= idx;
		size <= sz;
		if (m == MODE_LOAD) begin
			loads_sent++;
			last_load[idx] = sz;
		end else begin
			allocs_sent++;
		end
		do @(posedge clk); while (busy);
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// drain: no request in flight and every grant seen
	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (busy || outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		reg_writes++;
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	function automatic logic [SW-1:0] pick_load_size();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6) return SW'($urandom_range(1, 4000));
		if (r < 9) return SW'($urandom());
		return (r[0]) ? '1 : '0;
	endfunction

	// request sizes aimed at exact fits, small fits and misses
	function automatic logic [SW-1:0] pick_alloc_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15) return '0;
		if (r < 50) return last_load[$urandom_range(0, NB - 1)];
		if (r < 85) return SW'($urandom_range(1, 2000));
		return SW'($urandom());
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_block_count();
		case ($urandom_range(0, 9))
			0: return 6'd0;
			1: return 6'd1;
			2: return 6'd32;
			3: return 6'd63;
			4: return 6'd33;
			5: return CFG_DATA_W'($urandom_range(34, 62));
			default: return CFG_DATA_W'($urandom_range(2, 31));
		endcase
	endfunction

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill the whole table before any search can touch it
		for (int i = 0; i < NB; i++) begin
			if (i == 0) send_request(MODE_LOAD, LOAD_IDX_W'(i), '0);
			else if (i == NB - 1) send_request(MODE_LOAD, LOAD_IDX_W'(i), '1);
			else send_request(MODE_LOAD, LOAD_IDX_W'(i), SW'((i * 613) % 4000 + 1));
		end

		// first fit: zero size, full size hit and miss, alternating bit patterns
		send_request(MODE_ALLOC, '0, '0);
		send_request(MODE_ALLOC, '1, '1);
		send_request(MODE_ALLOC, '0, '1);
		send_request(MODE_ALLOC, '0, 16'd1500);
		send_request(MODE_LOAD, 5'd7, 16'h5555);
		send_request(MODE_LOAD, 5'd8, 16'hAAAA);
		send_request(MODE_ALLOC, '0, 16'h5555);

		// best fit with a tie between two equal entries
		settle();
		write_reg(REG_FIT_POLICY, CFG_DATA_W'(POLICY_BEST));
		send_request(MODE_LOAD, 5'd3, 16'd300);
		send_request(MODE_LOAD, 5'd12, 16'd300);
		send_request(MODE_ALLOC, '0, 16'd300);
		send_request(MODE_ALLOC, '0, 16'd300);
		send_request(MODE_ALLOC, '0, 16'd1);

		// empty search range
		settle();
		write_reg(REG_BLOCK_COUNT, 6'd0);
		send_request(MODE_ALLOC, '0, '0);

		// count above the table size
		settle();
		write_reg(REG_BLOCK_COUNT, 6'd63);
		send_request(MODE_ALLOC, '0, 16'd2000);

		// single entry, load past the search range
		settle();
		write_reg(REG_BLOCK_COUNT, 6'd1);
		send_request(MODE_ALLOC, '0, '0);
		send_request(MODE_ALLOC, '0, 16'd1);
		send_request(MODE_LOAD, 5'd31, '0);

		// writes to unused register slots change nothing
		settle();
		write_reg(2'd2, 6'h3F);
		write_reg(2'd3, 6'h2A);
		write_reg(REG_BLOCK_COUNT, 6'd32);
		send_request(MODE_ALLOC, '0, '0);
		settle();
		write_reg(REG_FIT_POLICY, CFG_DATA_W'(POLICY_FIRST));
		send_request(MODE_ALLOC, '0, 16'd4000);

		// random phases, each under its own register setting
		for (int p = 0; p < PHASES; p++) begin
			settle();
			if ($urandom_range(0, 1)) begin
				write_reg(REG_FIT_POLICY, CFG_DATA_W'($urandom_range(0, 1)));
				write_reg(REG_BLOCK_COUNT, pick_block_count());
			end else begin
				write_reg(REG_BLOCK_COUNT, pick_block_count());
				write_reg(REG_FIT_POLICY, CFG_DATA_W'($urandom_range(0, 1)));
			end
			if ($urandom_range(0, 9) == 0)
				write_reg(CFG_IDX_W'($urandom_range(2, 3)), CFG_DATA_W'($urandom()));
			gaps_on = ($urandom_range(0, 3) != 0);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if ($urandom_range(0, 99) < 35)
					send_request(MODE_LOAD, LOAD_IDX_W'($urandom_range(0, NB - 1)),
						pick_load_size());
				else
					send_request(MODE_ALLOC, LOAD_IDX_W'($urandom()), pick_alloc_size());
			end
		end

		settle();
		repeat (40) @(posedge clk);
		$display("covered %0d loads and %0d allocation requests over %0d register writes",
			loads_sent, allocs_sent, reg_writes);
		$display("both fit policies, search ranges from empty to beyond the table, %0d cycles",
			cycles);
		if (fail_count == 0) begin
			$display("** first_best_fit_block_allocator_unit: PASSED **");
		end else begin
			$display("** first_best_fit_block_allocator_unit: FAILED **");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+src
src/fbfa_pkg.sv
src/fbfa_ram.sv
src/fbfa_cmp.sv
src/first_best_fit_block_allocator_unit.sv
src/fbfa_checker.sv
sim/fbfa_alloc_checker.sv
sim/tb_first_best_fit_block_allocator_unit.sv
